// ----- rtl/isrd_pkg.sv -----
// Shared types, codes and defaults for the ISO 15693 response stream decoder.
package isrd_pkg;

  localparam int DEF_MAX_DECODED_BYTES = 128;
  localparam int DEF_MAX_FRAME_BYTES   = 256;
  localparam int QUEUE_DEPTH           = 4;
  localparam int SCAN_STEPS            = 5;

  localparam logic [4:0] SOF_CODE   = 5'h17;
  localparam logic [7:0] EOF_CODE   = 8'h1D;
  localparam logic [1:0] PAIR_ZERO  = 2'b01;
  localparam logic [1:0] PAIR_ONE   = 2'b10;
  localparam int         SCAN_START = 5;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BAD_SOF  = 3'd2;
  localparam logic [2:0] ST_BAD_SYM  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [3:0] valid_bits;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [3:0]  data_bits;
    logic [2:0]  status;
    logic [10:0] bit_count;
    logic        run_last;
  } out_word_t;

  // Results one input word leaves behind, in delivery order: byte, partial, status.
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  byte_val;
    logic        has_part;
    logic [7:0]  part_val;
    logic [2:0]  part_bits;
    logic        has_stat;
    logic [2:0]  stat;
    logic [10:0] cnt;
  } plan_t;

endpackage

// ----- rtl/iso15693_response_stream_decoder.sv -----
// Top level of the ISO 15693 card response stream decoder.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-----------------------------------
//   in_     | input     | in_valid / in_ready  | rx_byte, valid_bits, last
//   out_    | output    | out_valid / out_ready| kind, data_byte, data_bits, status,
//           |           |                      | bit_count, run_last
//
// One stream word is taken per cycle while the plan queue has room; the front
// end scans all of its symbol windows (up to five two-bit steps) in the same
// cycle it is accepted. Each word leaves zero to three result words; the back
// end hands out one per cycle while out_ready is high; a word with several
// results stays at the queue head until its last is loaded. in_ready drops
// only while the plan queue is full; a stalled output stalls the back end
// alone until the queue fills. Reset is synchronous on rst_n low and clears
// the decode state, the queue and out_valid; no clearing pass is needed.
module iso15693_response_stream_decoder import isrd_pkg::*; #(
  parameter int MAX_DECODED_BYTES = DEF_MAX_DECODED_BYTES,
  parameter int MAX_FRAME_BYTES   = DEF_MAX_FRAME_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic  accept;
  logic  push;
  plan_t plan;
  logic  full;
  logic  head_valid;
  plan_t head;
  logic  pop;

  // a word is taken whenever the queue has room, results pending or not
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  isrd_front #(
    .MaxDecodedBytes(MAX_DECODED_BYTES),
    .MaxFrameBytes  (MAX_FRAME_BYTES)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .word  (in_data),
    .push  (push),
    .plan  (plan)
  );

  isrd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (plan),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head      (head)
  );

  isrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/isrd_front.sv -----
// Front end: takes stream words, scans symbol windows and builds result plans.
module isrd_front import isrd_pkg::*; #(
  parameter int MaxDecodedBytes = DEF_MAX_DECODED_BYTES,
  parameter int MaxFrameBytes   = DEF_MAX_FRAME_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_word_t word,
  output logic     push,
  output plan_t    plan
);

  localparam int FBW = $clog2(MaxFrameBytes * 8 + 16);
  localparam int DBW = $clog2(MaxDecodedBytes * 8 + 1);
  localparam logic [FBW-1:0] FRAME_LIMIT = FBW'(MaxFrameBytes * 8);
  localparam logic [DBW-1:0] DEC_LIMIT   = DBW'(MaxDecodedBytes * 8);
  localparam logic [FBW-1:0] SCAN_RESET  = FBW'(SCAN_START);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RUN  = 4'b0010,
    PH_DONE = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [7:0]     prev_r, prev_nxt;
  logic [FBW-1:0] fbc_r, fbc_nxt;
  logic [FBW-1:0] scan_r, scan_nxt;
  logic [DBW-1:0] dec_r, dec_nxt;
  logic [7:0]     asm_r, asm_nxt;
  logic [2:0]     err_r, err_nxt;

  always_comb begin
    logic [3:0]   nb;
    logic [7:0]   rx_m;
    logic         first;
    logic         stop;
    logic [23:0]  win;
    logic [FBW:0] diff;
    logic [FBW:0] pos;
    logic [4:0]   off;
    logic [7:0]   w;
    logic         bitv;
    logic         out_range;

    nb        = word.last ? ((word.valid_bits > 4'd8) ? 4'd8 : word.valid_bits) : 4'd8;
    rx_m      = word.rx_byte & ~(8'hFF << nb);
    first     = (phase_r == PH_IDLE);
    stop      = 1'b0;
    win       = {8'h00, rx_m, prev_r};
    diff      = {1'b0, scan_r} + (FBW+1)'(8) - {1'b0, fbc_r};
    off       = diff[4:0];
    pos       = '0;
    w         = '0;
    bitv      = 1'b0;
    out_range = 1'b0;

    phase_nxt = first ? PH_RUN : phase_r;
    prev_nxt  = prev_r;
    fbc_nxt   = fbc_r;
    scan_nxt  = scan_r;
    dec_nxt   = dec_r;
    asm_nxt   = asm_r;
    err_nxt   = err_r;
    plan      = '0;

    if (phase_nxt == PH_RUN) begin
      if (fbc_r >= FRAME_LIMIT) begin
        phase_nxt = PH_ERR;
        err_nxt   = ST_OVERFLOW;
      end else begin
        prev_nxt = rx_m;
        fbc_nxt  = fbc_r + FBW'(nb);
        if (first) begin
          if (word.last && nb == 4'd0) begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_EMPTY;
          end else if (rx_m[4:0] != SOF_CODE) begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_BAD_SOF;
          end
        end
        // at most five two-bit steps fit in one stream word
        for (int k = 0; k < SCAN_STEPS; k++) begin
          if (phase_nxt == PH_RUN && !stop) begin
            pos       = {1'b0, scan_r} + (FBW+1)'(2 * k);
            out_range = word.last ? (pos + (FBW+1)'(5) >= {1'b0, fbc_nxt})
                                  : (pos + (FBW+1)'(8) >  {1'b0, fbc_nxt});
            if (out_range) begin
              stop = 1'b1;
            end else begin
              w        = 8'(win >> off);
              off      = off + 5'd2;
              scan_nxt = FBW'(pos + (FBW+1)'(2));
              if (w == EOF_CODE) begin
                phase_nxt = PH_DONE;
              end else if (w[1:0] != PAIR_ZERO && w[1:0] != PAIR_ONE) begin
                phase_nxt = PH_ERR;
                err_nxt   = ST_BAD_SYM;
              end else if (dec_nxt >= DEC_LIMIT) begin
                phase_nxt = PH_ERR;
                err_nxt   = ST_OVERFLOW;
              end else begin
                bitv                = (w[1:0] == PAIR_ONE);
                asm_nxt[dec_nxt[2:0]] = bitv;
                dec_nxt             = dec_nxt + DBW'(1);
                if (dec_nxt[2:0] == 3'd0) begin
                  plan.has_byte = 1'b1;
                  plan.byte_val = asm_nxt;
                  asm_nxt       = '0;
                end
              end
            end
          end
        end
      end
    end

    if (word.last) begin
      if (phase_nxt == PH_RUN) begin
        phase_nxt = PH_ERR;
        err_nxt   = ST_BAD_SYM;
      end
      plan.has_stat = 1'b1;
      if (phase_nxt == PH_DONE) begin
        if (dec_nxt[2:0] != 3'd0) begin
          plan.has_part  = 1'b1;
          plan.part_val  = asm_nxt;
          plan.part_bits = dec_nxt[2:0];
        end
        plan.stat = ST_OK;
        plan.cnt  = 11'(dec_nxt);
      end else begin
        plan.stat = err_nxt;
      end
      phase_nxt = PH_IDLE;
      prev_nxt  = '0;
      fbc_nxt   = '0;
      scan_nxt  = SCAN_RESET;
      dec_nxt   = '0;
      asm_nxt   = '0;
      err_nxt   = ST_OK;
    end
  end

  assign push = accept && (plan.has_byte || plan.has_part || plan.has_stat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prev_r  <= '0;
      fbc_r   <= '0;
      scan_r  <= SCAN_RESET;
      dec_r   <= '0;
      asm_r   <= '0;
      err_r   <= ST_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      fbc_r   <= fbc_nxt;
      scan_r  <= scan_nxt;
      dec_r   <= dec_nxt;
      asm_r   <= asm_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- rtl/isrd_fifo.sv -----
// Short plan queue between the front end and the result sequencer.
module isrd_fifo import isrd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  plan_t push_data,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output plan_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  plan_t           mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;

  assign full       = (cnt_r == CW'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/isrd_back.sv -----
// Back end: unpacks each plan into result words through an output register.
module isrd_back import isrd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  plan_t     head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      busy_r, busy_nxt;
  logic [2:0] pend_r, pend_nxt;
  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t word;
  logic [2:0] cur, sel, rem;
  logic      load;

  always_comb begin
    cur  = busy_r ? pend_r : {head.has_stat, head.has_part, head.has_byte};
    sel  = cur[0] ? 3'b001 : (cur[1] ? 3'b010 : 3'b100);
    rem  = cur & ~sel;
    load = head_valid && (!out_valid_r || out_ready);
    pop  = load && (rem == 3'b000);

    word          = '0;
    word.run_last = (rem == 3'b000);
    if (sel[0]) begin
      word.kind      = KIND_DATA;
      word.data_byte = head.byte_val;
      word.data_bits = 4'd8;
    end else if (sel[1]) begin
      word.kind      = KIND_DATA;
      word.data_byte = head.part_val;
      word.data_bits = {1'b0, head.part_bits};
    end else begin
      word.kind      = KIND_STATUS;
      word.status    = head.stat;
      word.bit_count = head.cnt;
    end

    busy_nxt = busy_r;
    pend_nxt = pend_r;
    if (load) begin
      busy_nxt = (rem != 3'b000);
      pend_nxt = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
